// ----- src/pscm_pkg.sv -----
`timescale 1ns / 1ps

package pscm_pkg;

  // defaults for the top level parameters
  localparam int COORD_BITS_DEF = 20;
  localparam int FRAC_BITS_DEF  = 8;

  // clearance result width
  localparam int OUT_BITS = 22;

  // coordinate differences are clamped to this magnitude before squaring
  localparam int MAG_BITS  = 23;
  localparam int CLAMP_MAG = 1 << 22;

  // sum of three squares and its square root
  localparam int SQ_BITS   = 2 * MAG_BITS;
  localparam int SUM_BITS  = SQ_BITS + 2;
  localparam int ROOT_BITS = SUM_BITS / 2;

  // radius width: dictionary radius and fallback radii up to 16 fraction bits
  localparam int DICT_BITS = 10;
  localparam int RAD_BITS  = 18;

  // configuration port
  localparam int ADDR_BITS = 4;
  localparam int DATA_BITS = 32;

  localparam logic [1:0] REG_PROBE_X = 2'd0;
  localparam logic [1:0] REG_PROBE_Y = 2'd1;
  localparam logic [1:0] REG_PROBE_Z = 2'd2;

  // element codes for the fallback radius
  localparam logic [1:0] ELEM_OTHER = 2'd0;
  localparam logic [1:0] ELEM_N     = 2'd1;
  localparam logic [1:0] ELEM_O     = 2'd2;
  localparam logic [1:0] ELEM_H     = 2'd3;

endpackage

// ----- src/pscm_if.sv -----
`timescale 1ns / 1ps

interface pscm_atom_if #(
  parameter int COORD_BITS = pscm_pkg::COORD_BITS_DEF
) ();
  logic                              valid;
  logic                              ready;
  logic signed [COORD_BITS-1:0]      atom_x;
  logic signed [COORD_BITS-1:0]      atom_y;
  logic signed [COORD_BITS-1:0]      atom_z;
  logic [pscm_pkg::DICT_BITS-1:0]    dict_radius;
  logic [1:0]                        element_code;
  logic                              selected;
  logic                              last_atom;

  modport source (
    output valid, atom_x, atom_y, atom_z, dict_radius, element_code, selected, last_atom,
    input  ready
  );
  modport sink (
    input  valid, atom_x, atom_y, atom_z, dict_radius, element_code, selected, last_atom,
    output ready
  );
endinterface

interface pscm_result_if ();
  logic                                valid;
  logic                                ready;
  logic signed [pscm_pkg::OUT_BITS-1:0] clearance;
  logic                                found;

  modport source (
    output valid, clearance, found,
    input  ready
  );
  modport sink (
    input  valid, clearance, found,
    output ready
  );
endinterface

// ----- src/pscm_isqrt.sv -----
`timescale 1ns / 1ps

// Restoring digit-by-digit square root, one result bit per cycle.
module pscm_isqrt (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [pscm_pkg::SUM_BITS-1:0]     radicand,
  output logic [pscm_pkg::ROOT_BITS-1:0]    root,
  output logic                              done
);

  localparam int RB    = pscm_pkg::ROOT_BITS;
  localparam int SB    = pscm_pkg::SUM_BITS;
  localparam int CNT_W = $clog2(RB);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [SB-1:0]     rad_sh;
  logic [RB+1:0]     rem;

  logic [RB+3:0]     rem_sh;
  logic [RB+3:0]     trial;
  logic [RB+3:0]     diff;
  logic              take;

  assign rem_sh = {rem, rad_sh[SB-1 -: 2]};
  assign trial  = {2'b00, root, 2'b01};
  assign diff   = rem_sh - trial;
  assign take   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy   <= 1'b1;
        cnt    <= CNT_W'(RB - 1);
        rad_sh <= radicand;
        rem    <= '0;
        root   <= '0;
      end else if (busy) begin
        rad_sh <= rad_sh << 2;
        if (take) begin
          rem  <= diff[RB+1:0];
          root <= {root[RB-2:0], 1'b1};
        end else begin
          rem  <= rem_sh[RB+1:0];
          root <= {root[RB-2:0], 1'b0};
        end
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - CNT_W'(1);
        end
      end
    end
  end

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy |-> !done)
    else $error("isqrt done while still busy");

endmodule

// ----- src/probe_sphere_clearance_min.sv -----
`timescale 1ns / 1ps

// Channel   Dir   Handshake          Payload
// atom      in    valid/ready        atom_x/y/z, dict_radius, element_code, selected, last_atom
// result    out   valid/ready        clearance, found
// apb       in    psel/penable/...   probe_x/y/z at byte addresses 0, 4, 8
//
// A selected atom is accepted, passes through the shared squarer and accumulator,
// launches the square root, waits in the bit-serial square root (one root bit
// per cycle) until it is seen done, then updates the minimum. An unselected atom is only accepted.
// A last atom then loads the output register in S_EMIT, which waits
// while a previous result is still untaken. Reset (rst, synchronous) clears
// the probe to 0, the running minimum to its top and the found flag.
module probe_sphere_clearance_min #(
  parameter int COORD_BITS = pscm_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = pscm_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  pscm_atom_if.sink                          atom,
  pscm_result_if.source                      result,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pscm_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [pscm_pkg::DATA_BITS-1:0]     pwdata,
  output logic [pscm_pkg::DATA_BITS-1:0]     prdata,
  output logic                               pready
);

  localparam int OB       = pscm_pkg::OUT_BITS;
  localparam int MB       = pscm_pkg::MAG_BITS;
  localparam int RB       = pscm_pkg::ROOT_BITS;
  localparam int RAD_W    = pscm_pkg::RAD_BITS;
  localparam int DIFF_W   = COORD_BITS + 1;
  localparam int CMP_W    = (DIFF_W > MB) ? DIFF_W : MB;
  localparam int CLR_W    = RB + 2;

  localparam int RAD_N_I  = (155 * (1 << FRAC_BITS) + 50) / 100;
  localparam int RAD_O_I  = (152 * (1 << FRAC_BITS) + 50) / 100;
  localparam int RAD_H_I  = (12 * (1 << FRAC_BITS) + 5) / 10;
  localparam int RAD_X_I  = (17 * (1 << FRAC_BITS) + 5) / 10;
  localparam int EMPTY_I  = -(1 << FRAC_BITS);

  localparam logic [RAD_W-1:0]         RAD_N     = RAD_W'(RAD_N_I);
  localparam logic [RAD_W-1:0]         RAD_O     = RAD_W'(RAD_O_I);
  localparam logic [RAD_W-1:0]         RAD_H     = RAD_W'(RAD_H_I);
  localparam logic [RAD_W-1:0]         RAD_X     = RAD_W'(RAD_X_I);
  localparam logic signed [OB-1:0]     EMPTY_CLR = OB'(EMPTY_I);
  localparam logic signed [OB-1:0]     CLR_MAX   = {1'b0, {(OB-1){1'b1}}};
  localparam logic signed [OB-1:0]     CLR_MIN   = {1'b1, {(OB-1){1'b0}}};
  localparam logic [CMP_W-1:0]         CLAMP     = CMP_W'(pscm_pkg::CLAMP_MAG);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_ROOT,
    S_UPD,
    S_EMIT
  } state_t;

  state_t state;

  // configuration
  logic signed [COORD_BITS-1:0] probe_x, probe_y, probe_z;
  logic                         cfg_wr;

  // latched item
  logic signed [COORD_BITS-1:0] ax, ay, az;
  logic [RAD_W-1:0]             rad;
  logic                         last;

  // squarer / accumulator
  logic [2:0]                   cnt;
  logic [MB-1:0]                mag;
  logic [pscm_pkg::SQ_BITS-1:0] sq;
  logic [pscm_pkg::SUM_BITS-1:0] acc;
  logic                         sq_start;
  logic                         sq_done;
  logic [RB-1:0]                sq_root;

  // running state
  logic signed [OB-1:0]         running_min;
  logic                         any_seen;

  // output register
  logic                         res_valid;
  logic signed [OB-1:0]         res_clr;
  logic                         res_found;

  logic                         in_fire;
  logic                         emit_ok;
  logic signed [DIFF_W-1:0]     d_sel;
  logic [DIFF_W-1:0]            d_abs;
  logic [CMP_W-1:0]             d_cmp;
  logic [MB-1:0]                mag_next;
  logic [RAD_W-1:0]             rad_next;
  logic signed [CLR_W-1:0]      clr_wide;
  logic signed [OB-1:0]         clr_sat;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[3:2])
      pscm_pkg::REG_PROBE_X: prdata = pscm_pkg::DATA_BITS'(probe_x);
      pscm_pkg::REG_PROBE_Y: prdata = pscm_pkg::DATA_BITS'(probe_y);
      pscm_pkg::REG_PROBE_Z: prdata = pscm_pkg::DATA_BITS'(probe_z);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_x <= '0;
      probe_y <= '0;
      probe_z <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        pscm_pkg::REG_PROBE_X: probe_x <= pwdata[COORD_BITS-1:0];
        pscm_pkg::REG_PROBE_Y: probe_y <= pwdata[COORD_BITS-1:0];
        pscm_pkg::REG_PROBE_Z: probe_z <= pwdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- datapath ----------------
  assign atom.ready = (state == S_IDLE);
  assign in_fire    = atom.valid && atom.ready;
  assign emit_ok    = !res_valid || result.ready;

  always_comb begin
    if (atom.dict_radius != '0) begin
      rad_next = RAD_W'(atom.dict_radius);
    end else begin
      case (atom.element_code)
        pscm_pkg::ELEM_N: rad_next = RAD_N;
        pscm_pkg::ELEM_O: rad_next = RAD_O;
        pscm_pkg::ELEM_H: rad_next = RAD_H;
        default:          rad_next = RAD_X;
      endcase
    end
  end

  // one axis per cycle through the shared abs/clamp stage
  always_comb begin
    case (cnt)
      3'd0:    d_sel = DIFF_W'(ax) - DIFF_W'(probe_x);
      3'd1:    d_sel = DIFF_W'(ay) - DIFF_W'(probe_y);
      default: d_sel = DIFF_W'(az) - DIFF_W'(probe_z);
    endcase
    d_abs    = d_sel[DIFF_W-1] ? DIFF_W'(-d_sel) : DIFF_W'(d_sel);
    d_cmp    = CMP_W'(d_abs);
    mag_next = (d_cmp > CLAMP) ? CLAMP[MB-1:0] : d_cmp[MB-1:0];
  end

  assign clr_wide = $signed({2'b00, sq_root}) - $signed(CLR_W'(rad));

  always_comb begin
    if (clr_wide > CLR_W'(CLR_MAX)) begin
      clr_sat = CLR_MAX;
    end else if (clr_wide < CLR_W'(CLR_MIN)) begin
      clr_sat = CLR_MIN;
    end else begin
      clr_sat = clr_wide[OB-1:0];
    end
  end

  pscm_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (acc),
    .root     (sq_root),
    .done     (sq_done)
  );

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= '0;
      sq_start    <= 1'b0;
      running_min <= CLR_MAX;
      any_seen    <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      sq_start <= 1'b0;
      if (res_valid && result.ready) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            ax   <= atom.atom_x;
            ay   <= atom.atom_y;
            az   <= atom.atom_z;
            rad  <= rad_next;
            last <= atom.last_atom;
            cnt  <= '0;
            acc  <= '0;
            if (atom.selected) begin
              state <= S_SUM;
            end else if (atom.last_atom) begin
              state <= S_EMIT;
            end
          end
        end
        S_SUM: begin
          // three-stage overlap: clamp, square, accumulate
          if (cnt < 3'd3) begin
            mag <= mag_next;
          end
          if (cnt >= 3'd1 && cnt <= 3'd3) begin
            sq <= mag * mag;
          end
          if (cnt >= 3'd2) begin
            acc <= acc + pscm_pkg::SUM_BITS'(sq);
          end
          if (cnt == 3'd4) begin
            sq_start <= 1'b1;
            state    <= S_ROOT;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        S_ROOT: begin
          if (sq_done) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          if (clr_sat < running_min) begin
            running_min <= clr_sat;
          end
          any_seen <= 1'b1;
          state    <= last ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (emit_ok) begin
            res_valid   <= 1'b1;
            res_clr     <= any_seen ? running_min : EMPTY_CLR;
            res_found   <= any_seen;
            running_min <= CLR_MAX;
            any_seen    <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid     = res_valid;
  assign result.clearance = res_clr;
  assign result.found     = res_found;

  a_empty_value: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.found) |-> (result.clearance == EMPTY_CLR))
    else $error("empty query result carries wrong clearance");

  a_done_in_root: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> (state == S_ROOT))
    else $error("square root finished outside its wait state");

  a_clear_after_emit: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && emit_ok) |=> (!any_seen && running_min == CLR_MAX))
    else $error("query state not cleared after result");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && emit_ok) |=> result.valid)
    else $error("result not presented after emit");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int CB = pscm_pkg::COORD_BITS_DEF;
  localparam int FB = pscm_pkg::FRAC_BITS_DEF;
  localparam int OB = pscm_pkg::OUT_BITS;
  localparam longint CLR_TOP = (longint'(1) << (OB - 1)) - 1;
  localparam longint CLR_BOT = -(longint'(1) << (OB - 1));
  localparam int COORD_TOP = (1 << (CB - 1)) - 1;
  localparam int COORD_BOT = -(1 << (CB - 1));
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int QUERY_ITEMS = 250;

  typedef struct packed {
    logic signed [CB-1:0]            atom_x;
    logic signed [CB-1:0]            atom_y;
    logic signed [CB-1:0]            atom_z;
    logic [pscm_pkg::DICT_BITS-1:0]  dict_radius;
    logic [1:0]                      element_code;
    logic                            selected;
    logic                            last_atom;
  } atom_t;

  typedef struct {
    logic signed [OB-1:0] clearance;
    logic                 found;
  } clearance_t;

  class clearance_board;
    logic signed [CB-1:0]       probe[3];
    logic signed [OB-1:0]       run_min;
    logic                       any_seen;
    clearance_t                 pending_results[$];
    int                         errors;

    function new();
      probe[0] = '0;
      probe[1] = '0;
      probe[2] = '0;
      run_min = OB'(CLR_TOP);
      any_seen = 1'b0;
      errors = 0;
    endfunction

    function void set_probe(logic [1:0] idx, logic signed [CB-1:0] v);
      probe[idx] = v;
    endfunction

    function longint root_floor(longint n);
      longint r;
      longint cand;
      r = 0;
      for (int b = pscm_pkg::ROOT_BITS; b >= 0; b--) begin
        cand = r | (longint'(1) << b);
        if (cand * cand <= n) r = cand;
      end
      return r;
    endfunction

    function longint fallback_radius(logic [1:0] code);
      longint one;
      one = longint'(1) << FB;
      case (code)
        pscm_pkg::ELEM_N:  return (155 * one + 50) / 100;
        pscm_pkg::ELEM_O:  return (152 * one + 50) / 100;
        pscm_pkg::ELEM_H:  return (12 * one + 5) / 10;
        default:           return (17 * one + 5) / 10;
      endcase
    endfunction

    function longint axis_mag(logic signed [CB-1:0] c, logic signed [CB-1:0] p);
      longint d;
      d = longint'(c) - longint'(p);
      if (d < 0) d = -d;
      if (d > pscm_pkg::CLAMP_MAG) d = pscm_pkg::CLAMP_MAG;
      return d;
    endfunction

    function void note_atom(atom_t a);
      longint ax, ay, az, distance, rad, clr;
      clearance_t r;
      if (a.selected) begin
        ax = axis_mag(a.atom_x, probe[pscm_pkg::REG_PROBE_X]);
        ay = axis_mag(a.atom_y, probe[pscm_pkg::REG_PROBE_Y]);
        az = axis_mag(a.atom_z, probe[pscm_pkg::REG_PROBE_Z]);
        distance = root_floor(ax * ax + ay * ay + az * az);
        rad = longint'(a.dict_radius);
        if (rad == 0) rad = fallback_radius(a.element_code);
        clr = distance - rad;
        if (clr > CLR_TOP) clr = CLR_TOP;
        if (clr < CLR_BOT) clr = CLR_BOT;
        if (clr < run_min) run_min = OB'(clr);
        any_seen = 1'b1;
      end
      if (a.last_atom) begin
        r.clearance = any_seen ? run_min : OB'(-(1 << FB));
        r.found = any_seen;
        pending_results.push_back(r);
        run_min = OB'(CLR_TOP);
        any_seen = 1'b0;
      end
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic signed [OB-1:0] clr, logic fnd);
      clearance_t e;
      if (pending_results.size() == 0) begin
        report($sformatf("result with none pending: clearance %0d found %0b", clr, fnd));
        return;
      end
      e = pending_results.pop_front();
      if (clr !== e.clearance)
        report($sformatf("clearance got %0d want %0d", clr, e.clearance));
      if (fnd !== e.found)
        report($sformatf("found got %0b want %0b", fnd, e.found));
    endtask

    function int outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic                           clk;
  logic                           rst;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [pscm_pkg::ADDR_BITS-1:0] paddr;
  logic [pscm_pkg::DATA_BITS-1:0] pwdata;
  logic [pscm_pkg::DATA_BITS-1:0] prdata;
  logic                           pready;

  int send_idle = 0;
  int recv_stall = 0;
  int cycles = 0;

  clearance_board board = new();

  pscm_atom_if #(.COORD_BITS(CB)) atom_ch ();
  pscm_result_if res_ch ();

  probe_sphere_clearance_min #(
    .COORD_BITS(CB),
    .FRAC_BITS (FB)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .atom   (atom_ch),
    .result (res_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready)
      board.check_result(res_ch.clearance, res_ch.found);
  end

  task automatic write_probe(logic [1:0] idx, logic signed [CB-1:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= pscm_pkg::ADDR_BITS'({idx, 2'b00});
    pwdata <= {{(pscm_pkg::DATA_BITS - CB){v[CB-1]}}, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board.set_probe(idx, v);
  endtask

  // valid stays high across back-to-back transfers; it drops only in a gap
  task automatic send_atom(atom_t a);
    while ($urandom_range(99) < send_idle) begin
      atom_ch.valid <= 1'b0;
      @(posedge clk);
    end
    atom_ch.valid <= 1'b1;
    atom_ch.atom_x <= a.atom_x;
    atom_ch.atom_y <= a.atom_y;
    atom_ch.atom_z <= a.atom_z;
    atom_ch.dict_radius <= a.dict_radius;
    atom_ch.element_code <= a.element_code;
    atom_ch.selected <= a.selected;
    atom_ch.last_atom <= a.last_atom;
    do @(posedge clk); while (!atom_ch.ready);
    board.note_atom(a);
  endtask

  // trailing atoms without last_atom give no result, so wait out the pipeline too
  task automatic settle();
    atom_ch.valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic atom_t mk_atom(int x, int y, int z, int rad, logic [1:0] elem,
                                    logic sel, logic last);
    atom_t a;
    a.atom_x = CB'(x);
    a.atom_y = CB'(y);
    a.atom_z = CB'(z);
    a.dict_radius = pscm_pkg::DICT_BITS'(rad);
    a.element_code = elem;
    a.selected = sel;
    a.last_atom = last;
    return a;
  endfunction

  function automatic logic signed [CB-1:0] near_coord(logic signed [CB-1:0] p);
    int span;
    int v;
    span = 1 << (4 * $urandom_range(1, 4));
    v = int'(p) + int'($urandom_range(0, 2 * span)) - span;
    if (v > COORD_TOP) v = COORD_TOP;
    if (v < COORD_BOT) v = COORD_BOT;
    return CB'(v);
  endfunction

  function automatic atom_t random_atom();
    atom_t a;
    int pick;
    if ($urandom_range(99) < 35) begin
      a.atom_x = CB'($urandom);
      a.atom_y = CB'($urandom);
      a.atom_z = CB'($urandom);
    end else begin
      a.atom_x = near_coord(board.probe[pscm_pkg::REG_PROBE_X]);
      a.atom_y = near_coord(board.probe[pscm_pkg::REG_PROBE_Y]);
      a.atom_z = near_coord(board.probe[pscm_pkg::REG_PROBE_Z]);
    end
    pick = $urandom_range(99);
    if (pick < 30) a.dict_radius = '0;
    else if (pick < 38) a.dict_radius = '1;
    else if (pick < 42) a.dict_radius = pscm_pkg::DICT_BITS'(1);
    else a.dict_radius = pscm_pkg::DICT_BITS'($urandom);
    a.element_code = 2'($urandom);
    a.selected = 1'b1;
    a.last_atom = 1'b0;
    return a;
  endfunction

  // queries of 1..8 atoms, mostly selected; a few queries select nothing
  task automatic run_queries(int n);
    int done;
    int len;
    bit empty;
    atom_t a;
    done = 0;
    while (done < n) begin
      len = $urandom_range(1, 8);
      empty = ($urandom_range(99) < 8);
      for (int i = 0; i < len; i++) begin
        a = random_atom();
        a.selected = !empty && ($urandom_range(99) < 85);
        a.last_atom = (i == len - 1);
        send_atom(a);
        done++;
      end
    end
  endtask

  initial begin
    logic signed [CB-1:0] px, py, pz;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    atom_ch.valid = 1'b0;
    atom_ch.atom_x = '0;
    atom_ch.atom_y = '0;
    atom_ch.atom_z = '0;
    atom_ch.dict_radius = '0;
    atom_ch.element_code = pscm_pkg::ELEM_OTHER;
    atom_ch.selected = 1'b0;
    atom_ch.last_atom = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: probe at reset origin
    send_atom(mk_atom(0, 0, 0, 0, pscm_pkg::ELEM_OTHER, 1'b0, 1'b1));      // empty query
    send_atom(mk_atom(0, 0, 0, 0, pscm_pkg::ELEM_OTHER, 1'b1, 1'b1));      // fallback radii
    send_atom(mk_atom(0, 0, 0, 0, pscm_pkg::ELEM_N, 1'b1, 1'b1));
    send_atom(mk_atom(0, 0, 0, 0, pscm_pkg::ELEM_O, 1'b1, 1'b1));
    send_atom(mk_atom(0, 0, 0, 0, pscm_pkg::ELEM_H, 1'b1, 1'b1));
    send_atom(mk_atom(0, 0, 0, 1023, pscm_pkg::ELEM_H, 1'b1, 1'b1));       // lowest clearance
    send_atom(mk_atom(COORD_TOP, COORD_TOP, COORD_TOP, 1, pscm_pkg::ELEM_N, 1'b1, 1'b0));
    send_atom(mk_atom(COORD_BOT, COORD_BOT, COORD_BOT, 0, pscm_pkg::ELEM_H, 1'b1, 1'b0));
    send_atom(mk_atom(5, -7, 3, 20, pscm_pkg::ELEM_O, 1'b0, 1'b1));        // unselected last
    send_atom(mk_atom(300, 400, 0, 10, pscm_pkg::ELEM_OTHER, 1'b1, 1'b0));
    send_atom(mk_atom(-3, 4, 0, 0, pscm_pkg::ELEM_O, 1'b1, 1'b0));
    send_atom(mk_atom(0, 0, 0, 0, pscm_pkg::ELEM_OTHER, 1'b0, 1'b0));
    send_atom(mk_atom(1000, 0, 0, 1023, pscm_pkg::ELEM_N, 1'b1, 1'b1));
    send_atom(mk_atom(COORD_BOT, COORD_TOP, COORD_BOT, 1, pscm_pkg::ELEM_OTHER, 1'b1, 1'b1));
    send_atom(mk_atom(-1, -1, -1, 1023, pscm_pkg::ELEM_H, 1'b0, 1'b0));
    send_atom(mk_atom(COORD_TOP, 0, COORD_BOT, 512, pscm_pkg::ELEM_N, 1'b0, 1'b1));
    send_atom(mk_atom(-1, -1, -1, 1023, pscm_pkg::ELEM_H, 1'b1, 1'b1));
    settle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        1: begin px = CB'(COORD_TOP); py = CB'(COORD_TOP); pz = CB'(COORD_TOP); end
        2: begin px = CB'(COORD_BOT); py = CB'(COORD_BOT); pz = CB'(COORD_BOT); end
        4: begin px = CB'(COORD_TOP); py = CB'(COORD_BOT); pz = '0; end
        6: begin px = '0; py = '0; pz = '0; end
        default: begin px = CB'($urandom); py = CB'($urandom); pz = CB'($urandom); end
      endcase
      write_probe(pscm_pkg::REG_PROBE_X, px);
      write_probe(pscm_pkg::REG_PROBE_Y, py);
      write_probe(pscm_pkg::REG_PROBE_Z, pz);
      case (p % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 77; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 77; end
        default: begin send_idle = 32; recv_stall = 32; end
      endcase
      // opposite corner from the probe gives the longest distance
      send_atom(mk_atom(px < 0 ? COORD_TOP : COORD_BOT, py < 0 ? COORD_TOP : COORD_BOT,
                        pz < 0 ? COORD_TOP : COORD_BOT, 1, pscm_pkg::ELEM_OTHER,
                        1'b1, 1'b1));
      run_queries(QUERY_ITEMS);
      settle();
    end

    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/pscm_pkg.sv
src/pscm_if.sv
src/pscm_isqrt.sv
src/probe_sphere_clearance_min.sv
tb/tb_top.sv
